/* rtl/m7ta_pkg.sv */
// m7ta_pkg: types, constants and helper functions for the mode 7 texel address block
// used by every module of the block, depends on nothing
`default_nettype none

package m7ta_pkg;

  localparam int TEX_WIDTH      = 1024;
  localparam int TEX_HEIGHT     = 1024;
  localparam int PAD_SIZE       = 8;
  localparam int MAX_MIP_LEVELS = 8;

  // padding period in texels and its reciprocal for a 15 bit dividend
  localparam int PAD_PER   = PAD_SIZE - 1;
  localparam int PAD_RECIP = ((1 << 21) + PAD_PER - 1) / PAD_PER;

  // floor(x / 10) = (x * CY_RECIP) >> 24 for x below 2^21
  localparam int CY_RECIP = 1677722;

  // divider geometry, shared by both division passes
  localparam int DIV_NUM_W = 37;
  localparam int DIV_DEN_W = 14;
  localparam int DIV_LANES = 2;

  typedef enum logic [2:0] {
    REG_POS_X     = 3'd0,
    REG_POS_Y     = 3'd1,
    REG_COS_THETA = 3'd2,
    REG_SIN_THETA = 3'd3,
    REG_ZOOM      = 3'd4,
    REG_SCREEN    = 3'd5,
    REG_PAD_ORG   = 3'd6,
    REG_MODE      = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [15:0] cos_theta;
    logic signed [15:0] sin_theta;
    logic        [15:0] zoom;
    logic        [9:0]  w;
    logic        [9:0]  h;
    logic        [9:0]  org_x;
    logic        [9:0]  org_y;
    logic               persp;
    logic        [3:0]  levels;
  } cfg_t;

  typedef struct packed {
    logic [9:0]  col;
    logic [9:0]  row;
    logic [30:0] a;
  } ctx_t;

  typedef struct packed {
    logic [2:0]  lvl;
    logic [9:0]  tx;
    logic [9:0]  ty;
    logic [19:0] idx;
    logic        wrapped;
  } res_t;

  // 2^(6*i) mod PAD_PER
  function automatic int pad_weight(int i);
    int p;
    p = 1 % PAD_PER;
    for (int k = 0; k < i; k++) begin
      p = (p * 64) % PAD_PER;
    end
    return p;
  endfunction

  localparam int PAD_NEGW = (PAD_PER - pad_weight(6)) % PAD_PER;

  // folds a 36 bit two's complement value into a small value of the same residue
  function automatic logic [14:0] pad_fold(logic [35:0] v);
    logic [14:0] acc;
    acc = v[35] ? 15'(PAD_NEGW) : 15'd0;
    for (int i = 0; i < 6; i++) begin
      acc = acc + 15'(15'(v[6*i +: 6]) * 15'(pad_weight(i)));
    end
    return acc;
  endfunction

  function automatic logic [10:0] mip_dim(int dim, logic [2:0] lvl);
    logic [10:0] v;
    v = 11'(dim) >> lvl;
    if (v == 11'd0) begin
      v = 11'd1;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

/* rtl/mode7_texel_address.sv */
// Mode 7 texel address generator: maps a screen pixel (col, row) to a texel of
// a mip-mapped ground texture. One pixel can be accepted on every clock while
// s_tready is high; a transaction passes the input register, two chained 37-stage
// divider pipelines (row scale a with floor(3W/H), then row scale b with the level
// rounding) with two registers between them, ten transform stages and the output
// register. The whole pipeline advances together; an output register and a
// one-entry skid stage let one more result land while the sink stalls, after which
// s_tready drops until the skid drains. The user must write registers through the
// apb port only while no pixel is in flight; the block does not enforce this.
// depends on m7ta_pkg, m7ta_cfg, m7ta_div, m7ta_xform
`default_nettype none

module mode7_texel_address import m7ta_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // col [9:0], row [19:10]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [47:0] m_tdata,   // mip_level [2:0], texel_x [12:3], texel_y [22:13],
                                      // texel_index [42:23]
  output logic      [0:0]  m_tuser    // wrapped [0]
);

  cfg_t cfg;
  logic en;

  logic skid_valid;
  res_t skid_res;
  res_t out_res;

  m7ta_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign en       = !skid_valid;
  assign s_tready = en;

  // input register
  logic       s0_vld;
  logic [9:0] s0_col;
  logic [9:0] s0_row;
  logic [10:0] s0_rp1;
  ctx_t       s0_ctx;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_vld <= 1'b0;
    end else if (en) begin
      s0_vld <= s_tvalid;
    end
    if (en) begin
      s0_col <= s_tdata[9:0];
      s0_row <= s_tdata[19:10];
    end
  end

  assign s0_rp1 = 11'(s0_row) + 11'd1;

  // first pass: a = (32*z*w + rp1) / (2*rp1) and q = 3w / h
  logic [DIV_LANES-1:0][DIV_NUM_W-1:0] d1_num;
  logic [DIV_LANES-1:0][DIV_DEN_W-1:0] d1_den;
  logic                                d1_vld;
  ctx_t                                d1_ctx;
  logic [DIV_LANES-1:0][DIV_NUM_W-1:0] d1_quo;

  always_comb begin
    s0_ctx.col = s0_col;
    s0_ctx.row = s0_row;
    s0_ctx.a   = '0;
    d1_num[0]  = DIV_NUM_W'({26'(26'(cfg.zoom) * 26'(cfg.w)), 5'd0}) + DIV_NUM_W'(s0_rp1);
    d1_den[0]  = DIV_DEN_W'({s0_rp1, 1'b0});
    d1_num[1]  = DIV_NUM_W'(12'(cfg.w) * 12'd3);
    d1_den[1]  = DIV_DEN_W'(cfg.h);
  end

  m7ta_div u_div_a (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s0_vld),
    .in_ctx    (s0_ctx),
    .in_num    (d1_num),
    .in_den    (d1_den),
    .out_valid (d1_vld),
    .out_ctx   (d1_ctx),
    .out_quo   (d1_quo)
  );

  // rp1 + q*h, then times zoom
  logic [10:0] d1_rp1;
  logic        q1_vld;
  ctx_t        q1_ctx;
  logic [12:0] q1_qh;
  logic        q2_vld;
  ctx_t        q2_ctx;
  logic [28:0] q2_nb;
  logic [10:0] q2_rp1;

  assign d1_rp1 = 11'(d1_ctx.row) + 11'd1;
  assign q2_rp1 = 11'(q2_ctx.row) + 11'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      q1_vld <= 1'b0;
      q2_vld <= 1'b0;
    end else if (en) begin
      q1_vld <= d1_vld;
      q2_vld <= q1_vld;
    end
    if (en) begin
      q1_ctx.col <= d1_ctx.col;
      q1_ctx.row <= d1_ctx.row;
      q1_ctx.a   <= d1_quo[0][30:0];
      q1_qh      <= 13'(d1_rp1) + 13'(22'(d1_quo[1][11:0]) * 22'(cfg.h));
      q2_ctx     <= q1_ctx;
      q2_nb      <= 29'(29'(cfg.zoom) * 29'(q1_qh));
    end
  end

  // second pass: b = (288*nb + 5*rp1) / (10*rp1) and r = (2*rp1*m + h) / (2h)
  logic [DIV_LANES-1:0][DIV_NUM_W-1:0] d2_num;
  logic [DIV_LANES-1:0][DIV_DEN_W-1:0] d2_den;
  logic                                d2_vld;
  ctx_t                                d2_ctx;
  logic [DIV_LANES-1:0][DIV_NUM_W-1:0] d2_quo;

  always_comb begin
    d2_num[0] = DIV_NUM_W'(38'(q2_nb) * 38'd288 + 38'(q2_rp1) * 38'd5);
    d2_den[0] = DIV_DEN_W'(14'(q2_rp1) * 14'd10);
    d2_num[1] = DIV_NUM_W'({15'(15'(q2_rp1) * 15'(cfg.levels)), 1'b0}) + DIV_NUM_W'(cfg.h);
    d2_den[1] = DIV_DEN_W'({cfg.h, 1'b0});
  end

  m7ta_div u_div_b (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (q2_vld),
    .in_ctx    (q2_ctx),
    .in_num    (d2_num),
    .in_den    (d2_den),
    .out_valid (d2_vld),
    .out_ctx   (d2_ctx),
    .out_quo   (d2_quo)
  );

  logic x_vld;
  res_t x_res;

  m7ta_xform u_xform (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .cfg       (cfg),
    .in_valid  (d2_vld),
    .in_ctx    (d2_ctx),
    .in_b      (d2_quo[0][32:0]),
    .in_r      (d2_quo[1][14:0]),
    .out_valid (x_vld),
    .out_res   (x_res)
  );

  // output register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (m_tready) begin
        out_res    <= skid_res;
        skid_valid <= 1'b0;
      end
    end else if (x_vld) begin
      if (m_tvalid && !m_tready) begin
        skid_res   <= x_res;
        skid_valid <= 1'b1;
      end else begin
        out_res  <= x_res;
        m_tvalid <= 1'b1;
      end
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = {5'd0, out_res.idx, out_res.ty, out_res.tx, out_res.lvl};
  assign m_tuser = out_res.wrapped;

endmodule

`default_nettype wire

/* rtl/m7ta_cfg.sv */
// m7ta_cfg: apb register file for camera, screen, padding and mode settings
// depends on m7ta_pkg
`default_nettype none

module m7ta_cfg import m7ta_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output cfg_t             cfg
);

  logic [23:0] pos_x;
  logic [23:0] pos_y;
  logic [15:0] cos_theta;
  logic [15:0] sin_theta;
  logic [15:0] zoom;
  logic [19:0] screen_size;
  logic [19:0] padding_origin;
  logic [4:0]  mode;
  reg_idx_t    idx;
  logic        wr;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[4:2]);
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x          <= 24'd220160;
      pos_y          <= 24'd194048;
      cos_theta      <= 16'd16384;
      sin_theta      <= 16'd0;
      zoom           <= 16'd328;
      screen_size    <= 20'd262400;
      padding_origin <= 20'd0;
      mode           <= 5'd17;
    end else if (wr) begin
      case (idx)
        REG_POS_X:     pos_x          <= pwdata[23:0];
        REG_POS_Y:     pos_y          <= pwdata[23:0];
        REG_COS_THETA: cos_theta      <= pwdata[15:0];
        REG_SIN_THETA: sin_theta      <= pwdata[15:0];
        REG_ZOOM:      zoom           <= pwdata[15:0];
        REG_SCREEN:    screen_size    <= pwdata[19:0];
        REG_PAD_ORG:   padding_origin <= pwdata[19:0];
        REG_MODE:      mode           <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_POS_X:     prdata = 32'(pos_x);
      REG_POS_Y:     prdata = 32'(pos_y);
      REG_COS_THETA: prdata = 32'(cos_theta);
      REG_SIN_THETA: prdata = 32'(sin_theta);
      REG_ZOOM:      prdata = 32'(zoom);
      REG_SCREEN:    prdata = 32'(screen_size);
      REG_PAD_ORG:   prdata = 32'(padding_origin);
      REG_MODE:      prdata = 32'(mode);
      default:       prdata = 32'd0;
    endcase
  end

  always_comb begin
    cfg.pos_x     = $signed(pos_x);
    cfg.pos_y     = $signed(pos_y);
    cfg.cos_theta = $signed(cos_theta);
    cfg.sin_theta = $signed(sin_theta);
    cfg.zoom      = zoom;
    cfg.w         = (screen_size[9:0] == 10'd0) ? 10'd1 : screen_size[9:0];
    cfg.h         = (screen_size[19:10] == 10'd0) ? 10'd1 : screen_size[19:10];
    cfg.org_x     = padding_origin[9:0];
    cfg.org_y     = padding_origin[19:10];
    cfg.persp     = mode[0];
    if (mode[4:1] == 4'd0) begin
      cfg.levels = 4'd1;
    end else if (mode[4:1] > 4'(MAX_MIP_LEVELS)) begin
      cfg.levels = 4'(MAX_MIP_LEVELS);
    end else begin
      cfg.levels = mode[4:1];
    end
  end

endmodule

`default_nettype wire

/* rtl/m7ta_div.sv */
// m7ta_div: two lane pipelined restoring divider, one quotient bit per stage
// carries the pixel context alongside; depends on m7ta_pkg
`default_nettype none

module m7ta_div import m7ta_pkg::*; (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   en,
  input  wire logic                                   in_valid,
  input  wire ctx_t                                   in_ctx,
  input  wire logic [DIV_LANES-1:0][DIV_NUM_W-1:0]    in_num,
  input  wire logic [DIV_LANES-1:0][DIV_DEN_W-1:0]    in_den,
  output logic                                        out_valid,
  output ctx_t                                        out_ctx,
  output logic      [DIV_LANES-1:0][DIV_NUM_W-1:0]    out_quo
);

  logic                                  vld  [DIV_NUM_W+1];
  ctx_t                                  ctx  [DIV_NUM_W+1];
  logic [DIV_LANES-1:0][DIV_NUM_W-1:0]   num  [DIV_NUM_W+1];
  logic [DIV_LANES-1:0][DIV_NUM_W-1:0]   quo  [DIV_NUM_W+1];
  logic [DIV_LANES-1:0][DIV_DEN_W-1:0]   den  [DIV_NUM_W+1];
  logic [DIV_LANES-1:0][DIV_DEN_W-1:0]   rem  [DIV_NUM_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
    if (en) begin
      ctx[0] <= in_ctx;
      num[0] <= in_num;
      den[0] <= in_den;
      rem[0] <= '0;
      quo[0] <= '0;
    end
  end

  for (genvar k = 0; k < DIV_NUM_W; k++) begin : g_stage
    logic [DIV_LANES-1:0][DIV_DEN_W:0]   trial;
    logic [DIV_LANES-1:0]                ge;
    logic [DIV_LANES-1:0][DIV_DEN_W-1:0] rem_next;

    always_comb begin
      for (int l = 0; l < DIV_LANES; l++) begin
        trial[l]    = {rem[k][l], num[k][l][DIV_NUM_W-1]};
        ge[l]       = trial[l] >= {1'b0, den[k][l]};
        rem_next[l] = ge[l] ? DIV_DEN_W'(trial[l] - {1'b0, den[k][l]})
                            : trial[l][DIV_DEN_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
      if (en) begin
        ctx[k+1] <= ctx[k];
        den[k+1] <= den[k];
        rem[k+1] <= rem_next;
        for (int l = 0; l < DIV_LANES; l++) begin
          num[k+1][l] <= {num[k][l][DIV_NUM_W-2:0], 1'b0};
          quo[k+1][l] <= {quo[k][l][DIV_NUM_W-2:0], ge[l]};
        end
      end
    end
  end

  assign out_valid = vld[DIV_NUM_W];
  assign out_ctx   = ctx[DIV_NUM_W];
  assign out_quo   = quo[DIV_NUM_W];

endmodule

`default_nettype wire

/* rtl/m7ta_xform.sv */
// m7ta_xform: scale, rotate, wrap and mip reduction stages after the row divisions
// depends on m7ta_pkg; fed by the second divider pass
`default_nettype none

module m7ta_xform import m7ta_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        en,
  input  wire cfg_t        cfg,
  input  wire logic        in_valid,
  input  wire ctx_t        in_ctx,
  input  wire logic [32:0] in_b,
  input  wire logic [14:0] in_r,
  output logic             out_valid,
  output res_t             out_res
);

  // stage 0: scale selection, centre, dx, level
  logic        [31:0] a_sel;
  logic        [32:0] b_sel;
  logic        [20:0] cy_x;
  logic        [17:0] cy_c;
  logic signed [19:0] dx_c;
  logic        [2:0]  lvl_c;

  logic               x0_vld;
  logic        [31:0] x0_a;
  logic        [32:0] x0_b;
  logic        [17:0] x0_cy;
  logic signed [19:0] x0_dx;
  logic        [9:0]  x0_row;
  logic        [2:0]  x0_lvl;

  always_comb begin
    a_sel = cfg.persp ? {1'b0, in_ctx.a} : 32'(32'(cfg.zoom) * 32'd480);
    b_sel = cfg.persp ? in_b : 33'(33'(cfg.zoom) * 33'd864);
    cy_x  = {cfg.h, 11'd0} + 21'd5;
    cy_c  = 18'((42'(cy_x) * 42'(CY_RECIP)) >> 24);
    dx_c  = 20'($signed({1'b0, in_ctx.col, 8'd0})) - 20'($signed({1'b0, cfg.w, 7'd0}));
    if (in_r == 15'd0 || in_r > 15'(cfg.levels)) begin
      lvl_c = 3'(cfg.levels - 4'd1);
    end else begin
      lvl_c = 3'(cfg.levels - 4'(in_r));
    end
  end

  // stage 1: dy and horizontal scale product
  logic signed [19:0] dy_c;
  logic signed [52:0] pa_c;

  logic               x1_vld;
  logic signed [52:0] x1_pa;
  logic        [32:0] x1_b;
  logic signed [19:0] x1_dy;
  logic        [17:0] x1_cy;
  logic        [2:0]  x1_lvl;

  assign dy_c = 20'($signed({1'b0, x0_row, 8'd0})) - 20'($signed({1'b0, x0_cy}));
  assign pa_c = 53'($signed({1'b0, x0_a})) * 53'(x0_dx);

  // stage 2: vertical scale product, round sx
  logic signed [53:0] pb_c;
  logic signed [52:0] pa_r;

  logic               x2_vld;
  logic signed [53:0] x2_pb;
  logic signed [36:0] x2_sx;
  logic        [17:0] x2_cy;
  logic        [2:0]  x2_lvl;

  assign pb_c = 54'($signed({1'b0, x1_b})) * 54'(x1_dy);
  assign pa_r = x1_pa + 53'sd32768;

  // stage 3: round sy
  logic signed [53:0] pb_r;

  logic               x3_vld;
  logic signed [36:0] x3_sx;
  logic signed [37:0] x3_sy;
  logic        [17:0] x3_cy;
  logic        [2:0]  x3_lvl;

  assign pb_r = x2_pb + 54'sd32768;

  // stage 4: rotation products
  logic               x4_vld;
  logic signed [52:0] x4_cs;
  logic signed [53:0] x4_ss;
  logic signed [52:0] x4_sc;
  logic signed [53:0] x4_cc;
  logic        [17:0] x4_cy;
  logic        [2:0]  x4_lvl;

  // stage 5: rotated sums, add centre and camera position
  logic signed [55:0] ex_c;
  logic signed [55:0] ey_c;
  logic signed [43:0] tx_c;
  logic signed [43:0] ty_c;

  logic               x5_vld;
  logic signed [43:0] x5_tx;
  logic signed [43:0] x5_ty;
  logic        [2:0]  x5_lvl;

  always_comb begin
    ex_c = 56'(x4_cs) - 56'(x4_ss) + 56'sd8192;
    ey_c = 56'(x4_sc) + 56'(x4_cc) + 56'sd8192;
    tx_c = 44'(cfg.pos_x) + 44'($signed({1'b0, cfg.w, 7'd0})) + 44'(ex_c >>> 14);
    ty_c = 44'(cfg.pos_y) + 44'($signed({1'b0, x4_cy})) + 44'(ey_c >>> 14);
  end

  // stage 6: texture bounds, offset into padding box, residue fold
  logic               wrap_c;
  logic signed [35:0] hx_c;
  logic signed [35:0] hy_c;

  logic               x6_vld;
  logic               x6_wrap;
  logic        [14:0] x6_fx;
  logic        [14:0] x6_fy;
  logic        [9:0]  x6_px;
  logic        [9:0]  x6_py;
  logic        [2:0]  x6_lvl;

  always_comb begin
    wrap_c = (x5_tx < 44'sd0) || (x5_tx >= 44'(TEX_WIDTH * 256)) ||
             (x5_ty < 44'sd0) || (x5_ty >= 44'(TEX_HEIGHT * 256));
    hx_c   = 36'(x5_tx >>> 8) - 36'($signed({1'b0, cfg.org_x}));
    hy_c   = 36'(x5_ty >>> 8) - 36'($signed({1'b0, cfg.org_y}));
  end

  // stage 7: finish the residue, integer texel coordinate
  logic [14:0] qx_c;
  logic [14:0] qy_c;
  logic [5:0]  dmx_c;
  logic [5:0]  dmy_c;
  logic [10:0] tix_c;
  logic [10:0] tiy_c;

  logic        x7_vld;
  logic        x7_wrap;
  logic [10:0] x7_tix;
  logic [10:0] x7_tiy;
  logic [2:0]  x7_lvl;

  always_comb begin
    qx_c  = 15'((37'(x6_fx) * 37'(PAD_RECIP)) >> 21);
    qy_c  = 15'((37'(x6_fy) * 37'(PAD_RECIP)) >> 21);
    dmx_c = 6'(x6_fx - 15'(21'(qx_c) * 21'(PAD_PER)));
    dmy_c = 6'(x6_fy - 15'(21'(qy_c) * 21'(PAD_PER)));
    tix_c = x6_wrap ? 11'(cfg.org_x) + 11'(dmx_c) : {1'b0, x6_px};
    tiy_c = x6_wrap ? 11'(cfg.org_y) + 11'(dmy_c) : {1'b0, x6_py};
  end

  // stage 8: mip reduction and clamp
  logic [10:0] ux_c;
  logic [10:0] uy_c;
  logic [10:0] mw_c;
  logic [10:0] mh_c;

  logic        x8_vld;
  logic        x8_wrap;
  logic [9:0]  x8_ux;
  logic [9:0]  x8_uy;
  logic [2:0]  x8_lvl;

  always_comb begin
    mw_c = mip_dim(TEX_WIDTH, x7_lvl);
    mh_c = mip_dim(TEX_HEIGHT, x7_lvl);
    ux_c = x7_tix >> x7_lvl;
    uy_c = x7_tiy >> x7_lvl;
    if (ux_c > mw_c - 11'd1) begin
      ux_c = mw_c - 11'd1;
    end
    if (uy_c > mh_c - 11'd1) begin
      uy_c = mh_c - 11'd1;
    end
  end

  // stage 9: linear index
  logic [21:0] idx_c;

  assign idx_c = 22'(x8_uy) * 22'(mip_dim(TEX_WIDTH, x8_lvl)) + 22'(x8_ux);

  always_ff @(posedge clk) begin
    if (rst) begin
      x0_vld    <= 1'b0;
      x1_vld    <= 1'b0;
      x2_vld    <= 1'b0;
      x3_vld    <= 1'b0;
      x4_vld    <= 1'b0;
      x5_vld    <= 1'b0;
      x6_vld    <= 1'b0;
      x7_vld    <= 1'b0;
      x8_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      x0_vld    <= in_valid;
      x1_vld    <= x0_vld;
      x2_vld    <= x1_vld;
      x3_vld    <= x2_vld;
      x4_vld    <= x3_vld;
      x5_vld    <= x4_vld;
      x6_vld    <= x5_vld;
      x7_vld    <= x6_vld;
      x8_vld    <= x7_vld;
      out_valid <= x8_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x0_a   <= a_sel;
      x0_b   <= b_sel;
      x0_cy  <= cy_c;
      x0_dx  <= dx_c;
      x0_row <= in_ctx.row;
      x0_lvl <= lvl_c;

      x1_pa  <= pa_c;
      x1_b   <= x0_b;
      x1_dy  <= dy_c;
      x1_cy  <= x0_cy;
      x1_lvl <= x0_lvl;

      x2_pb  <= pb_c;
      x2_sx  <= 37'(pa_r >>> 16);
      x2_cy  <= x1_cy;
      x2_lvl <= x1_lvl;

      x3_sx  <= x2_sx;
      x3_sy  <= 38'(pb_r >>> 16);
      x3_cy  <= x2_cy;
      x3_lvl <= x2_lvl;

      x4_cs  <= 53'(cfg.cos_theta) * 53'(x3_sx);
      x4_ss  <= 54'(cfg.sin_theta) * 54'(x3_sy);
      x4_sc  <= 53'(cfg.sin_theta) * 53'(x3_sx);
      x4_cc  <= 54'(cfg.cos_theta) * 54'(x3_sy);
      x4_cy  <= x3_cy;
      x4_lvl <= x3_lvl;

      x5_tx  <= tx_c;
      x5_ty  <= ty_c;
      x5_lvl <= x4_lvl;

      x6_wrap <= wrap_c;
      x6_fx   <= pad_fold(hx_c);
      x6_fy   <= pad_fold(hy_c);
      x6_px   <= x5_tx[17:8];
      x6_py   <= x5_ty[17:8];
      x6_lvl  <= x5_lvl;

      x7_wrap <= x6_wrap;
      x7_tix  <= tix_c;
      x7_tiy  <= tiy_c;
      x7_lvl  <= x6_lvl;

      x8_wrap <= x7_wrap;
      x8_ux   <= ux_c[9:0];
      x8_uy   <= uy_c[9:0];
      x8_lvl  <= x7_lvl;

      out_res.lvl     <= x8_lvl;
      out_res.tx      <= x8_ux;
      out_res.ty      <= x8_uy;
      out_res.idx     <= idx_c[19:0];
      out_res.wrapped <= x8_wrap;
    end
  end

  a_lvl_range: assert property (@(posedge clk) disable iff (rst)
    x0_vld |-> (4'(x0_lvl) < cfg.levels))
    else $error("mip level not below level count");

  a_residue: assert property (@(posedge clk) disable iff (rst)
    x6_vld |-> (6'(dmx_c) < 6'(PAD_PER)) && (6'(dmy_c) < 6'(PAD_PER)))
    else $error("padding residue out of period");

  a_texel_in_mip: assert property (@(posedge clk) disable iff (rst)
    x8_vld |-> (11'(x8_ux) < mip_dim(TEX_WIDTH, x8_lvl)) &&
               (11'(x8_uy) < mip_dim(TEX_HEIGHT, x8_lvl)))
    else $error("texel outside selected mip level");

endmodule

`default_nettype wire
